// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/htld_pkg.sv =====
package htld_pkg;

  // default sizes
  localparam int NODE_CAPACITY_DEF  = 512;
  localparam int STACK_CAPACITY_DEF = 256;

  // code bits per data byte
  localparam int BYTE_W = 8;

  // marker byte that announces a leaf ('1')
  localparam logic [7:0] LEAF_MARK = 8'h31;

  // input word kinds
  localparam logic OP_TREE = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // result status codes
  localparam logic [1:0] ST_SYMBOL   = 2'd0;
  localparam logic [1:0] ST_EARLY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic       load_data;  // latch a data byte and its bit count
    logic       new_inner;  // allocate internal node, attach, push
    logic       new_leaf;   // allocate leaf, attach, maybe pop
    logic       clear;      // drop the tree
    logic       reload;     // refill cached stack top from stack memory
    logic       step;       // walk one code bit
    logic       flush;      // close the data byte
    logic       err;        // issue an error word
    logic [1:0] err_code;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_mark;
    logic node_full;
    logic stack_full;
    logic stack_empty;
    logic stack_one;
    logic top_left;
    logic root_leaf;
    logic walk_hold;
    logic last_bit;
    logic pend_valid;
    logic slot_free;
  } dp_stat_t;

endpackage

// ===== sv/htld_ctrl.sv =====
module htld_ctrl
  import htld_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_opcode,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_FLUSH  = 5'b00100,
    S_RELOAD = 5'b01000,
    S_ERR    = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    PH_EMPTY = 4'b0001,
    PH_MARK  = 4'b0010,
    PH_SYM   = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [1:0] err_code, err_code_next;

  // next state and commands
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    err_code_next = err_code;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && phase == PH_DONE && in_opcode == OP_TREE) begin
          // tree word after a complete tree: drop the old tree first
          cmd.clear  = 1'b1;
          phase_next = PH_EMPTY;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            if (in_opcode == OP_DATA) begin
              if (phase != PH_DONE) begin
                err_code_next = ST_EARLY;
                state_next    = S_ERR;
              end else begin
                cmd.load_data = 1'b1;
                state_next    = stat.root_leaf ? S_FLUSH : S_WALK;
              end
            end else if (phase == PH_SYM) begin
              if (stat.node_full) begin
                cmd.clear     = 1'b1;
                phase_next    = PH_EMPTY;
                err_code_next = ST_OVERFLOW;
                state_next    = S_ERR;
              end else begin
                cmd.new_leaf = 1'b1;
                if (stat.stack_empty) begin
                  phase_next = PH_DONE;
                end else if (!stat.top_left) begin
                  phase_next = PH_MARK;
                end else if (stat.stack_one) begin
                  phase_next = PH_DONE;
                end else begin
                  phase_next = PH_MARK;
                  state_next = S_RELOAD;
                end
              end
            end else if (stat.is_mark) begin
              phase_next = PH_SYM;
            end else if (stat.node_full || stat.stack_full) begin
              cmd.clear     = 1'b1;
              phase_next    = PH_EMPTY;
              err_code_next = ST_OVERFLOW;
              state_next    = S_ERR;
            end else begin
              cmd.new_inner = 1'b1;
              phase_next    = PH_MARK;
            end
          end
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (!stat.walk_hold && stat.last_bit) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid || stat.slot_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RELOAD: begin
        cmd.reload = 1'b1;
        state_next = S_IDLE;
      end
      S_ERR: begin
        if (stat.slot_free) begin
          cmd.err      = 1'b1;
          cmd.err_code = err_code;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_EMPTY;
      err_code <= ST_SYMBOL;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      err_code <= err_code_next;
    end
  end

endmodule

// ===== sv/htld_dp.sv =====
module htld_dp
  import htld_pkg::*;
#(
  parameter int NODE_CAPACITY  = NODE_CAPACITY_DEF,
  parameter int STACK_CAPACITY = STACK_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  input  logic       cfg_valid,
  input  logic [2:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic [1:0] out_status,
  output logic       out_last
);

  localparam int NW  = $clog2(NODE_CAPACITY);
  localparam int NUW = $clog2(NODE_CAPACITY + 1);
  localparam int SW  = $clog2(STACK_CAPACITY);
  localparam int STW = $clog2(STACK_CAPACITY + 1);
  localparam int AW  = NW + 1;
  localparam int ND  = 2 * NODE_CAPACITY;

  // child link: the child's leaf flag and symbol travel with its index
  typedef struct packed {
    logic          leaf;
    logic [7:0]    sym;
    logic [NW-1:0] idx;
  } link_t;

  // link memory, addressed by {node, side}
  link_t         nmem [ND];
  link_t         rd;
  link_t         wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  // build stack memory: frames below the cached top
  logic [NW-1:0] smem [STACK_CAPACITY];
  logic [NW-1:0] srd;
  logic [SW-1:0] sraddr, swaddr;
  logic          swe;

  logic [2:0]     pad_bits;
  logic           root_leaf;
  logic [NUW-1:0] nodes_used;
  logic [STW-1:0] stack_top, stack_top_next, stack_dec, sr_full;
  logic [NW-1:0]  top_node;
  logic           top_left;
  logic [NW-1:0]  cursor, cursor_next;
  logic [7:0]     bits, bits_next;
  logic [3:0]     bits_left, bits_left_next;
  logic           last_flag;
  logic           pend_valid;
  logic [7:0]     pend_sym;
  logic [NW-1:0]  new_idx;
  logic           hit, walk_hold, advance, slot_free;
  logic           emit, e_last;
  logic [7:0]     e_sym;
  logic [1:0]     e_status;

  assign new_idx   = nodes_used[NW-1:0];
  assign slot_free = !out_valid || out_ready;
  assign hit       = rd.leaf;
  assign walk_hold = hit && pend_valid && !slot_free;
  assign advance   = cmd.step && !walk_hold;
  assign stack_dec = stack_top - STW'(1);

  // status to the controller
  always_comb begin
    stat.is_mark     = (in_byte == LEAF_MARK);
    stat.node_full   = (nodes_used >= NUW'(NODE_CAPACITY));
    stat.stack_full  = (stack_top >= STW'(STACK_CAPACITY));
    stat.stack_empty = (stack_top == '0);
    stat.stack_one   = (stack_top == STW'(1));
    stat.top_left    = top_left;
    stat.root_leaf   = root_leaf;
    stat.walk_hold   = walk_hold;
    stat.last_bit    = (bits_left == 4'd1);
    stat.pend_valid  = pend_valid;
    stat.slot_free   = slot_free;
  end

  // decode cursor and bit shifter
  always_comb begin
    cursor_next    = cursor;
    bits_next      = bits;
    bits_left_next = bits_left;
    if (cmd.clear) begin
      cursor_next = '0;
    end
    if (cmd.load_data) begin
      bits_next      = in_byte;
      bits_left_next = in_final ? (4'(BYTE_W) - {1'b0, pad_bits}) : 4'(BYTE_W);
    end
    if (advance) begin
      cursor_next    = hit ? '0 : rd.idx;
      bits_next      = {bits[6:0], 1'b0};
      bits_left_next = bits_left - 4'd1;
    end
    if (cmd.flush && last_flag) begin
      cursor_next = '0;
    end
  end

  // read the link for the next bit as soon as cursor and bit are known
  assign raddr = {cursor_next, bits_next[7]};

  // attach a new node to the cached parent
  assign we    = (cmd.new_inner || cmd.new_leaf) && (stack_top != '0);
  assign waddr = {top_node, top_left};
  always_comb begin
    wdata.leaf = cmd.new_leaf;
    wdata.sym  = cmd.new_leaf ? in_byte : 8'd0;
    wdata.idx  = new_idx;
  end

  // stack depth and spill of the parent frame on a left push
  always_comb begin
    stack_top_next = stack_top;
    if (cmd.clear) begin
      stack_top_next = '0;
    end else if (cmd.new_inner) begin
      if (stack_top == '0 || !top_left) begin
        stack_top_next = stack_top + STW'(1);
      end
    end else if (cmd.new_leaf && stack_top != '0 && top_left) begin
      stack_top_next = stack_dec;
    end
  end

  assign swe     = cmd.new_inner && (stack_top != '0) && !top_left;
  assign swaddr  = stack_dec[SW-1:0];
  assign sr_full = stack_top_next - STW'(1);
  assign sraddr  = sr_full[SW-1:0];

  // memories
  always_ff @(posedge clk) begin
    if (we) begin
      nmem[waddr] <= wdata;
    end
    rd <= nmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem[swaddr] <= top_node;
    end
    srd <= smem[sraddr];
  end

  // result word source
  always_comb begin
    emit     = 1'b0;
    e_sym    = pend_sym;
    e_status = ST_SYMBOL;
    e_last   = 1'b0;
    if (advance && hit && pend_valid) begin
      emit = 1'b1;
    end else if (cmd.flush && pend_valid) begin
      emit   = 1'b1;
      e_last = 1'b1;
    end else if (cmd.err) begin
      emit     = 1'b1;
      e_sym    = 8'd0;
      e_status = cmd.err_code;
      e_last   = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_bits   <= 3'd0;
      root_leaf  <= 1'b0;
      nodes_used <= '0;
      stack_top  <= '0;
      top_left   <= 1'b0;
      cursor     <= '0;
      bits_left  <= 4'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pad_bits <= cfg_data;
      end
      if (cmd.clear) begin
        nodes_used <= '0;
      end else if (cmd.new_inner || cmd.new_leaf) begin
        nodes_used <= nodes_used + NUW'(1);
      end
      if ((cmd.new_inner || cmd.new_leaf) && new_idx == '0) begin
        root_leaf <= cmd.new_leaf;
      end
      stack_top <= stack_top_next;
      if (cmd.new_inner) begin
        top_left <= 1'b0;
      end else if (cmd.new_leaf && stack_top != '0 && !top_left) begin
        top_left <= 1'b1;
      end else if (cmd.reload) begin
        top_left <= 1'b1;
      end
      cursor    <= cursor_next;
      bits_left <= bits_left_next;
      if (advance && hit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bits <= bits_next;
    if (cmd.load_data) begin
      last_flag <= in_final;
    end
    if (cmd.new_inner) begin
      top_node <= new_idx;
    end else if (cmd.reload) begin
      top_node <= srd;
    end
    if (advance && hit) begin
      pend_sym <= rd.sym;
    end
    if (emit) begin
      out_symbol <= e_sym;
      out_status <= e_status;
      out_last   <= e_last;
    end
  end

endmodule

// ===== sv/huffman_tree_load_and_decode.sv =====
// Channel  | Signals                          | Word
// ---------+----------------------------------+------------------------------------
// s_axis   | tvalid tready tdata tuser tlast  | tree byte or code byte
// m_axis   | tvalid tready tdata tuser tlast  | decoded symbol or error status
// cfg      | valid ready data                 | pad bit count for the final byte
//
// Tree word: a leaf that closes a nested right subtree adds a stack refill
// step; a tree word after a complete tree first has the old tree dropped.
// Error word: via an error state. Code word: latched, walked over N code bits
// (8, less the pad bits on the final byte); one dependent link memory read per
// bit sets the pace. Output stalls hold the walk while a second symbol waits,
// and the byte close or an error word until the output slot frees. Sync reset, memories uncleared.
`include "assert_macros.svh"

module huffman_tree_load_and_decode
  import htld_pkg::*;
#(
  parameter int NODE_CAPACITY  = NODE_CAPACITY_DEF,
  parameter int STACK_CAPACITY = STACK_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic       s_axis_tuser,   // [0] opcode
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] symbol
  output logic [1:0] m_axis_tuser,   // [1:0] status
  output logic       m_axis_tlast,   // run_end
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data        // pad_bits
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  htld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_opcode (s_axis_tuser),
    .stat      (stat),
    .in_ready  (s_axis_tready),
    .cmd       (cmd)
  );

  htld_dp #(
    .NODE_CAPACITY  (NODE_CAPACITY),
    .STACK_CAPACITY (STACK_CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (s_axis_tdata),
    .in_final   (s_axis_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_symbol (m_axis_tdata),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  // checks
  `ASSERT_IMPLIES(a_err_slot, clk, rst, cmd.err, stat.slot_free, "error word onto full output")
  `ASSERT_IMPLIES(a_err_word, clk, rst, m_axis_tvalid && (m_axis_tuser != ST_SYMBOL), (m_axis_tdata == 8'd0) && m_axis_tlast, "error word malformed")
  `ASSERT_NEXT(a_walk_start, clk, rst, cmd.load_data && !stat.root_leaf, cmd.step, "bit walk did not start")

endmodule
